[hw/rtl/affine_inverse_map_address_assert.svh]
// Assertion macros for the inverse affine address generator.
`ifndef AFFINE_INVERSE_MAP_ADDRESS_ASSERT_SVH
`define AFFINE_INVERSE_MAP_ADDRESS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define AIMA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define AIMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/aima_pkg.sv]
// Package: widths, limits and register indexes of the inverse affine address generator.
`default_nettype none

package aima_pkg;

   localparam int COORD_W    = 12;
   localparam int COEF_W     = 24;
   localparam int SHIFT_W    = 23;
   localparam int DIM_W      = 13;
   localparam int PIX_FRAC_W = 8;
   localparam int DELTA_W    = 24;
   localparam int PROD_W     = 48;
   localparam int FRAC_W     = 24;
   localparam int ROUND_W    = PROD_W + 1 - FRAC_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [DIM_W-1:0]  MAX_DIM    = DIM_W'(4096);
   localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W+1)'(1) << (FRAC_W - 1);

   localparam logic signed [COEF_W-1:0]  INV_ONE    = COEF_W'(65536);
   localparam logic signed [COEF_W-1:0]  INV_ZERO   = '0;
   localparam logic signed [SHIFT_W-1:0] SHIFT_ZERO = '0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INV_A      = 3'd0,
      CSR_INV_B      = 3'd1,
      CSR_INV_C      = 3'd2,
      CSR_INV_D      = 3'd3,
      CSR_SHIFT_X    = 3'd4,
      CSR_SHIFT_Y    = 3'd5,
      CSR_SRC_WIDTH  = 3'd6,
      CSR_SRC_HEIGHT = 3'd7
   } csr_index_type;

   typedef logic [COORD_W-1:0]        coord_type;
   typedef logic signed [DELTA_W-1:0] delta_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic [ROUND_W-1:0]        round_type;

endpackage

`default_nettype wire

[hw/rtl/affine_inverse_map_address.sv]
// Top level: pipelined inverse affine source address generator, nearest neighbor.
//
// Usage:
//   Input channel req_*: one output pixel coordinate (out_x, out_y) per transaction.
//   Result channel rsp_*: source coordinate (src_x, src_y) and in_range flag; when
//   the coordinate falls outside the source map both coordinates are zero.
//   csr_*: write-only register port, index 0..7 = inv_a, inv_b, inv_c, inv_d,
//   shift_x, shift_y, src_width, src_height. Write only while no transaction is
//   in flight.
// Throughput: one transaction per cycle while the response is not stalled, set by
//   the five register stages (delta, multiply, sum, magnitude, round/compare),
//   each one operation deep.
// Reset (synchronous, active high): all stages empty, identity matrix, zero
//   shift, 4096 x 4096 source map.
// Stall: a stalled response holds; stages behind it keep filling bubbles, and
//   req_stall rises only once every stage holds a transaction.
`default_nettype none

module affine_inverse_map_address import aima_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [COORD_W-1:0]     req_out_x,
   input  wire logic [COORD_W-1:0]     req_out_y,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [COORD_W-1:0]          rsp_src_x,
   output logic [COORD_W-1:0]          rsp_src_y,
   output logic                        rsp_in_range,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration
   logic signed [COEF_W-1:0]  inv_a_ff, inv_b_ff, inv_c_ff, inv_d_ff;
   logic signed [SHIFT_W-1:0] shift_x_ff, shift_y_ff;
   logic [DIM_W-1:0]          src_width_ff, src_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_a_ff      <= INV_ONE;
         inv_b_ff      <= INV_ZERO;
         inv_c_ff      <= INV_ZERO;
         inv_d_ff      <= INV_ONE;
         shift_x_ff    <= SHIFT_ZERO;
         shift_y_ff    <= SHIFT_ZERO;
         src_width_ff  <= MAX_DIM;
         src_height_ff <= MAX_DIM;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_INV_A:      inv_a_ff      <= csr_data[COEF_W-1:0];
            CSR_INV_B:      inv_b_ff      <= csr_data[COEF_W-1:0];
            CSR_INV_C:      inv_c_ff      <= csr_data[COEF_W-1:0];
            CSR_INV_D:      inv_d_ff      <= csr_data[COEF_W-1:0];
            CSR_SHIFT_X:    shift_x_ff    <= csr_data[SHIFT_W-1:0];
            CSR_SHIFT_Y:    shift_y_ff    <= csr_data[SHIFT_W-1:0];
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data[DIM_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_data[DIM_W-1:0];
            default:        inv_a_ff      <= inv_a_ff;
         endcase
      end
   end

   // stage valids and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en_out;

   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en4       = !v4_ff || en_out;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff        <= req_valid;
         if (en2)    v2_ff        <= v1_ff;
         if (en3)    v3_ff        <= v2_ff;
         if (en4)    v4_ff        <= v3_ff;
         if (en_out) rsp_valid_ff <= v4_ff;
      end
   end

   // stage 1: subtract translation (Q.8)
   delta_type dx_in, dy_in, dx_ff, dy_ff;

   assign dx_in = DELTA_W'({req_out_x, PIX_FRAC_W'(0)}) - DELTA_W'(shift_x_ff);
   assign dy_in = DELTA_W'({req_out_y, PIX_FRAC_W'(0)}) - DELTA_W'(shift_y_ff);

   always_ff @(posedge clock) begin
      if (en1) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // stage 2: four 24x24 products (Q.24)
   prod_type pax_in, pby_in, pcx_in, pdy_in;
   prod_type pax_ff, pby_ff, pcx_ff, pdy_ff;

   assign pax_in = inv_a_ff * dx_ff;
   assign pby_in = inv_b_ff * dy_ff;
   assign pcx_in = inv_c_ff * dx_ff;
   assign pdy_in = inv_d_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         pax_ff <= pax_in;
         pby_ff <= pby_in;
         pcx_ff <= pcx_in;
         pdy_ff <= pdy_in;
      end
   end

   // stage 3: row sums
   prod_type sx_in, sy_in, sx_ff, sy_ff;

   assign sx_in = pax_ff + pby_ff;
   assign sy_in = pcx_ff + pdy_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
   end

   // stage 4: sign and magnitude
   logic [PROD_W-1:0] magx_in, magy_in, magx_ff, magy_ff;
   logic              signx_ff, signy_ff;

   assign magx_in = sx_ff[PROD_W-1] ? PROD_W'(-sx_ff) : PROD_W'(sx_ff);
   assign magy_in = sy_ff[PROD_W-1] ? PROD_W'(-sy_ff) : PROD_W'(sy_ff);

   always_ff @(posedge clock) begin
      if (en4) begin
         magx_ff  <= magx_in;
         magy_ff  <= magy_in;
         signx_ff <= sx_ff[PROD_W-1];
         signy_ff <= sy_ff[PROD_W-1];
      end
   end

   // stage 5: round half away from zero, range check
   logic [PROD_W:0]  sumx, sumy;
   round_type        rndx, rndy;
   logic             negx, negy, ok;
   logic [DIM_W-1:0] lim_w, lim_h;
   coord_type        src_x_in, src_y_in, src_x_ff, src_y_ff;
   logic             in_range_ff;

   assign sumx  = {1'b0, magx_ff} + ROUND_HALF;
   assign sumy  = {1'b0, magy_ff} + ROUND_HALF;
   assign rndx  = sumx[PROD_W:FRAC_W];
   assign rndy  = sumy[PROD_W:FRAC_W];
   assign negx  = signx_ff && (rndx != '0);
   assign negy  = signy_ff && (rndy != '0);
   assign lim_w = (src_width_ff > MAX_DIM) ? MAX_DIM : src_width_ff;
   assign lim_h = (src_height_ff > MAX_DIM) ? MAX_DIM : src_height_ff;
   assign ok    = !negx && !negy && (rndx < ROUND_W'(lim_w)) && (rndy < ROUND_W'(lim_h));

   assign src_x_in = ok ? rndx[COORD_W-1:0] : '0;
   assign src_y_in = ok ? rndy[COORD_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (en_out) begin
         src_x_ff    <= src_x_in;
         src_y_ff    <= src_y_in;
         in_range_ff <= ok;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_src_x    = src_x_ff;
   assign rsp_src_y    = src_y_ff;
   assign rsp_in_range = in_range_ff;

`include "affine_inverse_map_address_assert.svh"

   `AIMA_ASSERT_NOW(a_zero_when_out, clock, reset, rsp_valid && !rsp_in_range,
      (rsp_src_x == '0) && (rsp_src_y == '0), "out-of-range transaction with nonzero coordinate")
   `AIMA_ASSERT_NOW(a_stall_only_full, clock, reset, req_stall,
      rsp_valid && rsp_stall && v1_ff && v2_ff && v3_ff && v4_ff,
      "request stalled with a free stage")
   `AIMA_ASSERT_NEXT(a_sum_holds, clock, reset, v3_ff && !en3,
      v3_ff && $stable(sx_ff) && $stable(sy_ff), "held sum stage changed")

endmodule

`default_nettype wire

[bench/tb.sv]
// Testbench for affine_inverse_map_address: directed and random transactions against a scoreboard.
`timescale 1ns / 1ps

module tb;
   import aima_pkg::*;

   typedef struct packed {
      coord_type src_x;
      coord_type src_y;
      logic      in_range;
   } src_address_type;

   class address_scoreboard;
      logic signed [COEF_W-1:0]  coef_a, coef_b, coef_c, coef_d;
      logic signed [SHIFT_W-1:0] shift_x, shift_y;
      logic [DIM_W-1:0]          map_width, map_height;
      src_address_type           expected_addresses[$];
      int                        mismatches;

      function new();
         coef_a     = INV_ONE;
         coef_b     = INV_ZERO;
         coef_c     = INV_ZERO;
         coef_d     = INV_ONE;
         shift_x    = SHIFT_ZERO;
         shift_y    = SHIFT_ZERO;
         map_width  = MAX_DIM;
         map_height = MAX_DIM;
         mismatches = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_INV_A:      coef_a     = value[COEF_W-1:0];
            CSR_INV_B:      coef_b     = value[COEF_W-1:0];
            CSR_INV_C:      coef_c     = value[COEF_W-1:0];
            CSR_INV_D:      coef_d     = value[COEF_W-1:0];
            CSR_SHIFT_X:    shift_x    = value[SHIFT_W-1:0];
            CSR_SHIFT_Y:    shift_y    = value[SHIFT_W-1:0];
            CSR_SRC_WIDTH:  map_width  = value[DIM_W-1:0];
            CSR_SRC_HEIGHT: map_height = value[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      // Q.24 to integer, ties away from zero
      function longint round_to_pixel(longint v, output bit negative);
         longint magnitude;
         magnitude = (v < 0) ? -v : v;
         magnitude = (magnitude + (longint'(1) << (FRAC_W - 1))) >> FRAC_W;
         negative  = (v < 0) && (magnitude != 0);
         return magnitude;
      endfunction

      function src_address_type map_address(coord_type ox, coord_type oy);
         longint          dx, dy, sx, sy, rx, ry, w, h;
         bit              neg_x, neg_y, ok;
         src_address_type res;
         dx = (longint'(ox) << PIX_FRAC_W) - longint'(shift_x);
         dy = (longint'(oy) << PIX_FRAC_W) - longint'(shift_y);
         sx = longint'(coef_a) * dx + longint'(coef_b) * dy;
         sy = longint'(coef_c) * dx + longint'(coef_d) * dy;
         rx = round_to_pixel(sx, neg_x);
         ry = round_to_pixel(sy, neg_y);
         w  = (map_width > MAX_DIM) ? longint'(MAX_DIM) : longint'(map_width);
         h  = (map_height > MAX_DIM) ? longint'(MAX_DIM) : longint'(map_height);
         ok = !neg_x && !neg_y && (rx < w) && (ry < h);
         res.src_x    = ok ? coord_type'(rx) : '0;
         res.src_y    = ok ? coord_type'(ry) : '0;
         res.in_range = ok;
         return res;
      endfunction

      function void note_request(coord_type ox, coord_type oy);
         expected_addresses.push_back(map_address(ox, oy));
      endfunction

      function void check_response(coord_type x, coord_type y, logic in_range);
         src_address_type want;
         if (expected_addresses.size() == 0) begin
            $error("response with no transaction outstanding: src_x %0d src_y %0d", x, y);
            mismatches++;
            return;
         end
         want = expected_addresses.pop_front();
         if (want.src_x !== x) begin
            $error("src_x: expected %0d, actual %0d", want.src_x, x);
            mismatches++;
         end
         if (want.src_y !== y) begin
            $error("src_y: expected %0d, actual %0d", want.src_y, y);
            mismatches++;
         end
         if (want.in_range !== in_range) begin
            $error("in_range: expected %0d, actual %0d", want.in_range, in_range);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_addresses.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [COORD_W-1:0]     req_out_x = '0;
   logic [COORD_W-1:0]     req_out_y = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [COORD_W-1:0]     rsp_src_x;
   logic [COORD_W-1:0]     rsp_src_y;
   logic                   rsp_in_range;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   bit                     jitter_on = 1'b1;
   bit                     holdoff_armed = 1'b0;
   address_scoreboard      sb;

   affine_inverse_map_address dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_out_x    (req_out_x),
      .req_out_y    (req_out_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_src_x    (rsp_src_x),
      .rsp_src_y    (rsp_src_y),
      .rsp_in_range (rsp_in_range),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_item(coord_type x, coord_type y);
      @(negedge clock);
      while (jitter_on && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_out_x <= x;
      req_out_y <= y;
      do @(posedge clock); while (req_stall);
      sb.note_request(x, y);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic apply_config(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
                               logic signed [COEF_W-1:0] c, logic signed [COEF_W-1:0] d,
                               logic signed [SHIFT_W-1:0] shx,
                               logic signed [SHIFT_W-1:0] shy,
                               logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      drain();
      write_reg(CSR_INV_A, CSR_DATA_W'(a));
      write_reg(CSR_INV_B, CSR_DATA_W'(b));
      write_reg(CSR_INV_C, CSR_DATA_W'(c));
      write_reg(CSR_INV_D, CSR_DATA_W'(d));
      write_reg(CSR_SHIFT_X, CSR_DATA_W'(shx));
      write_reg(CSR_SHIFT_Y, CSR_DATA_W'(shy));
      write_reg(CSR_SRC_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_SRC_HEIGHT, CSR_DATA_W'(h));
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic longint corner(int width, longint unit);
      case ($urandom_range(3))
         0:       return -(longint'(1) << (width - 1));
         1:       return (longint'(1) << (width - 1)) - 1;
         2:       return 0;
         default: return unit;
      endcase
   endfunction

   // response side: random stall, plus one long hold-off when armed
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (holdoff_armed) begin
            holdoff_armed = 1'b0;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= jitter_on && ($urandom_range(99) < 15);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_src_x, rsp_src_y, rsp_in_range);
      end
   end

   initial begin
      #4_000_000;
      $display("[affine_inverse_map_address] ERROR");
      $finish;
   end

   initial begin
      logic signed [COEF_W-1:0]  a, b, c, d;
      logic signed [SHIFT_W-1:0] shx, shy;
      logic [DIM_W-1:0]          w, h;
      logic [DIM_W-1:0]          size_corners[4];
      int                        mode;
      sb = new();
      size_corners = '{DIM_W'(0), DIM_W'(1), MAX_DIM, DIM_W'(8191)};
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset configuration: identity, full map
      send_item(0, 0);
      send_item(4095, 4095);
      send_item(0, 4095);
      send_item(4095, 0);
      send_item(1234, 2345);

      // half-pixel ties and values just below zero
      apply_config(INV_ONE, INV_ZERO, INV_ZERO, INV_ONE, 23'sd128, 23'sd127, MAX_DIM, MAX_DIM);
      send_item(0, 0);
      send_item(1, 0);
      send_item(5, 0);
      send_item(4095, 4095);

      // zero width
      apply_config(INV_ONE, INV_ZERO, INV_ZERO, INV_ONE, SHIFT_ZERO, SHIFT_ZERO, '0, MAX_DIM);
      send_item(3, 3);
      send_item(0, 0);

      // oversized map clamps to the maximum
      apply_config(INV_ONE, INV_ZERO, INV_ZERO, INV_ONE, SHIFT_ZERO, SHIFT_ZERO,
                   DIM_W'(8191), DIM_W'(4097));
      send_item(4095, 4095);
      send_item(4095, 0);

      // one-pixel map
      apply_config(INV_ONE, INV_ZERO, INV_ZERO, INV_ONE, SHIFT_ZERO, SHIFT_ZERO,
                   DIM_W'(1), DIM_W'(1));
      send_item(0, 0);
      send_item(1, 0);
      send_item(0, 1);

      // coefficient and shift extremes
      apply_config(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000,
                   23'sh400000, 23'sh3FFFFF, MAX_DIM, MAX_DIM);
      send_item(0, 0);
      send_item(4095, 4095);
      send_item(4095, 0);

      // half scale: +0.5 rounds up, -0.5 rounds to -1
      apply_config(24'sd32768, INV_ZERO, INV_ZERO, -24'sd32768, SHIFT_ZERO, SHIFT_ZERO,
                   MAX_DIM, MAX_DIM);
      send_item(1, 0);
      send_item(0, 1);

      for (int phase = 0; phase < 10; phase++) begin
         mode = phase % 4;
         case (mode)
            0: begin
               a = COEF_W'($urandom); b = COEF_W'($urandom);
               c = COEF_W'($urandom); d = COEF_W'($urandom);
               shx = SHIFT_W'($urandom); shy = SHIFT_W'($urandom);
               w = DIM_W'($urandom); h = DIM_W'($urandom);
            end
            1: begin
               // random rotation/scale, coefficients within +/-1.5, with modest translation
               a = COEF_W'($urandom_range(2 * 98304) - 98304);
               b = COEF_W'($urandom_range(2 * 98304) - 98304);
               c = COEF_W'($urandom_range(2 * 98304) - 98304);
               d = COEF_W'($urandom_range(2 * 98304) - 98304);
               shx = SHIFT_W'($urandom_range(2 * 262144) - 262144);
               shy = SHIFT_W'($urandom_range(2 * 262144) - 262144);
               w = DIM_W'($urandom_range(4096, 1));
               h = DIM_W'($urandom_range(4096, 1));
            end
            2: begin
               // small map, near-unity diagonal
               a = COEF_W'($urandom_range(65536 + 8192, 65536 - 8192));
               b = COEF_W'($urandom_range(2 * 4096) - 4096);
               c = COEF_W'($urandom_range(2 * 4096) - 4096);
               d = COEF_W'($urandom_range(65536 + 8192, 65536 - 8192));
               shx = SHIFT_W'($urandom_range(2 * 2048) - 2048);
               shy = SHIFT_W'($urandom_range(2 * 2048) - 2048);
               w = DIM_W'($urandom_range(64, 1));
               h = DIM_W'($urandom_range(64, 1));
            end
            default: begin
               a = COEF_W'(corner(COEF_W, 65536));
               b = COEF_W'(corner(COEF_W, 65536));
               c = COEF_W'(corner(COEF_W, 65536));
               d = COEF_W'(corner(COEF_W, 65536));
               shx = SHIFT_W'(corner(SHIFT_W, 256));
               shy = SHIFT_W'(corner(SHIFT_W, 256));
               w = size_corners[2'($urandom_range(3))];
               h = size_corners[2'($urandom_range(3))];
            end
         endcase
         apply_config(a, b, c, d, shx, shy, w, h);
         if (phase == 4) begin
            jitter_on = 1'b0;
            holdoff_armed = 1'b1;
         end
         for (int n = 0; n < 115; n++) begin
            if ($urandom_range(4) == 0) begin
               send_item(coord_type'($urandom_range(63)), coord_type'($urandom_range(63)));
            end else begin
               send_item(coord_type'($urandom), coord_type'($urandom));
            end
         end
         jitter_on = 1'b1;
      end

      drain();
      if (sb.mismatches == 0) begin
         $display("[affine_inverse_map_address] OK");
      end else begin
         $display("[affine_inverse_map_address] ERROR");
      end
      $finish;
   end

endmodule
